### src/cholesky_lower_factor_macros.svh
// Assertion helpers for the Cholesky block.
`ifndef CHOLESKY_LOWER_FACTOR_MACROS_SVH
`define CHOLESKY_LOWER_FACTOR_MACROS_SVH

// Implication that holds outside reset.
`define CLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define CLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/clf_pkg.sv
package clf_pkg;
  localparam int DIM_DEF = 4;
  localparam int FRAC_DEF = 16;
  localparam int IDX_W = 2;
  localparam int VAL_W = 32;
  localparam int SIZE_W = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIAG_ACC, ST_DIAG_MUL, ST_SQRT, ST_OFF_ACC, ST_OFF_MUL,
    ST_DIV, ST_DIV_WR, ST_EMIT_RD, ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             start;
  } load_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             clamped;
    logic             last;
  } factor_item_t;
endpackage

### src/clf_if.sv
interface clf_load_if import clf_pkg::*; ();
  logic       valid;
  logic       ready;
  load_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clf_factor_if import clf_pkg::*; ();
  logic         valid;
  logic         ready;
  factor_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clf_cfg_if import clf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/cholesky_lower_factor.sv
// Cholesky lower factor, signed Q16.16. Load items store one element of the
// lower triangle each; an item with start set is stored and then the
// leading active_size block is factored and L is sent out row-major, n*n
// items, zeros above the diagonal, last on the final one. Loads pass
// through the front queue. A factorization uses a bit-serial square root
// and a bit-serial divider. Loads queue up during a run.
module cholesky_lower_factor import clf_pkg::*; #(
  parameter int DIM = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  clf_load_if.sink     in_ch,
  clf_factor_if.source out_ch,
  clf_cfg_if.sink      cfg_ch
);
  logic [SIZE_W-1:0] size_r;
  logic              q_valid, q_pop, q_store;
  load_item_t        q_item;

  // active_size register, sampled by the back end when a run starts
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= SIZE_RESET;
    else if (cfg_ch.valid) size_r <= cfg_ch.data;
  end

  clf_front #(.DIM(DIM)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_pop, .q_item, .q_store
  );

  clf_back #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .size(size_r), .q_valid, .q_pop, .q_item, .q_store, .out_ch
  );
endmodule

### src/clf_front.sv
// Accepts load items and queues them, marking out-of-range or upper-triangle stores so they are not stored.
module clf_front import clf_pkg::*; #(
  parameter int DIM = DIM_DEF,
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  clf_load_if.sink   in_ch,
  output logic       q_valid,
  input  logic       q_pop,
  output load_item_t q_item,
  output logic       q_store
);
  localparam int PW = $clog2(DEPTH);
  load_item_t       mem_r [DEPTH];
  logic             st_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  logic             push, keep;

  assign in_ch.ready = (cnt_r != (PW+1)'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign keep = (int'(in_ch.data.row) < DIM) && (int'(in_ch.data.col) < DIM)
                && (in_ch.data.col <= in_ch.data.row);
  assign q_valid = (cnt_r != '0);
  assign q_item = mem_r[rp_r];
  assign q_store = st_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_ch.data;
      st_r[wp_r] <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (int'(wp_r) == DEPTH-1) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (int'(rp_r) == DEPTH-1) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

### src/clf_sqrt.sv
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle;
// done is raised after the last result bit.
module clf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x_r, res_r, bit_r;
  logic        busy_r;

  assign root = res_r[31:0];
  assign done = busy_r && (bit_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r && bit_r != '0) begin
      if (x_r >= res_r + bit_r) begin
        x_r <= x_r - (res_r + bit_r);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end
endmodule

### src/clf_div.sv
// Restoring divider: signed 64-bit numerator over positive 32-bit pivot,
// one quotient bit per cycle, quotient truncated and saturated to 32 bits.
module clf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic        neg_r, busy_r;
  logic [32:0] trial;
  logic [63:0] mag;
  logic [64:0] sq;

  assign mag = num[63] ? (~num + 64'd1) : num;
  assign trial = {rem_r[31:0], q_r[63]} - {1'b0, den_r};
  assign done = busy_r && (cnt_r == 7'd64);

  always_comb begin
    sq = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
    if (!neg_r && q_r > 64'h7FFF_FFFF) quot = 32'h7FFF_FFFF;
    else if (neg_r && q_r > 64'h8000_0000) quot = 32'h8000_0000;
    else quot = sq[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[63];
      cnt_r <= '0;
    end else if (busy_r && cnt_r != 7'd64) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r + 7'd1;
    end
  end
endmodule

### src/clf_back.sv
// Stores loads, runs the factorization sequencer and emits L.
module clf_back import clf_pkg::*; #(
  parameter int DIM = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] size,
  input  logic              q_valid,
  output logic              q_pop,
  input  load_item_t        q_item,
  input  logic              q_store,
  clf_factor_if.source      out_ch
);
  localparam int AW = $clog2(DIM*DIM);
  localparam int CW = $clog2(DIM);

  logic [VAL_W-1:0] a_mem [DIM*DIM];
  logic [VAL_W-1:0] l_mem [DIM*DIM];
  logic [DIM-1:0]   flag_r, flag_nxt;
  back_state_t      st_r, st_nxt;
  logic [CW-1:0]    k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, n1_r, n1_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [VAL_W-1:0] pa_r, pb_r, aval_r, pivot_r, pivot_nxt;
  logic [63:0]      prod_r;
  logic [AW-1:0]    la_a, la_b, lw_a, aa;
  logic             lw_en;
  logic [VAL_W-1:0] lw_d;
  logic [63:0]      rem;
  logic [64:0]      diff, sum;
  logic             sq_start, sq_done, dv_start, dv_done;
  logic [31:0]      sq_root, dv_q;
  logic             out_valid_r, out_valid_nxt;
  factor_item_t     out_r, out_nxt;
  logic [VAL_W-1:0] rd_r;
  logic [1:0]       pipe_r;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    addr = AW'(int'(r) * DIM + int'(c));
  endfunction

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  // saturating accumulate of signed 64-bit products
  assign sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};
  always_comb begin
    if (sum[64] != sum[63]) acc_nxt = sum[64] ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF;
    else acc_nxt = sum[63:0];
  end

  // A * 2^FRAC_BITS minus sum, saturating
  always_comb begin
    logic [64:0] sc;
    sc = 65'($signed(aval_r)) <<< FRAC_BITS;
    diff = sc - {acc_r[63], acc_r};
    if (diff[64] != diff[63]) rem = diff[64] ? 64'h8000_0000_0000_0000
                                             : 64'h7FFF_FFFF_FFFF_FFFF;
    else rem = diff[63:0];
  end

  clf_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(rem),
                   .done(sq_done), .root(sq_root));
  clf_div u_div (.clk, .rst_n, .start(dv_start), .num(rem), .den(pivot_r),
                 .done(dv_done), .quot(dv_q));

  always_ff @(posedge clk) begin
    if (q_pop && q_store) a_mem[addr(CW'(q_item.row), CW'(q_item.col))] <= q_item.value;
    if (lw_en) l_mem[lw_a] <= lw_d;
    pa_r <= l_mem[la_a];
    pb_r <= l_mem[la_b];
    aval_r <= a_mem[aa];
    rd_r <= l_mem[la_a];
    prod_r <= 64'($signed(pa_r)) * 64'($signed(pb_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flag_r <= flag_nxt;
    n1_r <= n1_nxt;
    pivot_r <= pivot_nxt;
    out_r <= out_nxt;
    if (st_r == ST_DIAG_ACC || st_r == ST_OFF_ACC) begin
      if (j_r == '0) acc_r <= '0;
    end else if ((st_r == ST_DIAG_MUL || st_r == ST_OFF_MUL) && pipe_r == 2'd1) begin
      acc_r <= acc_nxt;
    end
  end

  // Sequencer. The accumulate path runs j over 0..k-1: issue read (ACC),
  // product lands via pa/pb, then prod_r (MUL); a zero j count skips straight on.
  // pipe_r counts cycles since the last ACC state and sticks at 3, so the
  // root and divider units are started at most once per visit.
  always_ff @(posedge clk) begin
    if (!rst_n) pipe_r <= '0;
    else if (st_r == ST_DIAG_ACC || st_r == ST_OFF_ACC) pipe_r <= '0;
    else if (pipe_r != 2'd3) pipe_r <= pipe_r + 2'd1;
  end

  always_comb begin
    logic [SIZE_W-1:0] n;
    st_nxt = st_r;
    k_nxt = k_r;
    i_nxt = i_r;
    j_nxt = j_r;
    n1_nxt = n1_r;
    flag_nxt = flag_r;
    pivot_nxt = pivot_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    q_pop = 1'b0;
    la_a = addr(k_r, j_r);
    la_b = addr(k_r, j_r);
    aa = addr(k_r, k_r);
    lw_en = 1'b0;
    lw_a = addr(k_r, k_r);
    lw_d = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    n = size;
    if (n == '0) n = SIZE_W'(1);
    if (int'(n) > DIM) n = SIZE_W'(DIM);
    if (out_ch.ready) out_valid_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.start) begin
            n1_nxt = CW'(n - SIZE_W'(1));
            k_nxt = '0;
            j_nxt = '0;
            st_nxt = ST_DIAG_ACC;
          end
        end
      end
      ST_DIAG_ACC: begin
        // Each term: read L[k][j] twice, wait pipeline, add.
        la_a = addr(k_r, j_r);
        la_b = addr(k_r, j_r);
        st_nxt = (j_r == k_r) ? ST_SQRT : ST_DIAG_MUL;
      end
      ST_DIAG_MUL: begin
        la_a = addr(k_r, j_r);
        la_b = addr(k_r, j_r);
        if (pipe_r == 2'd1) begin
          j_nxt = j_r + 1'b1;
          st_nxt = ST_DIAG_ACC;
        end
      end
      ST_SQRT: begin
        if (pipe_r == 2'd0) begin
          sq_start = !(rem[63] || rem == '0);
          flag_nxt[k_r] = rem[63] || rem == '0;
          if (rem[63] || rem == '0) begin
            pivot_nxt = '0;
            lw_en = 1'b1;
            lw_d = '0;
            i_nxt = k_r + 1'b1;
            j_nxt = '0;
            st_nxt = (k_r == n1_r) ? ST_DIV_WR : ST_OFF_ACC;
          end
        end else if (sq_done) begin
          pivot_nxt = sq_root[31] ? 32'h7FFF_FFFF : sq_root;
          if (sq_root == '0) flag_nxt[k_r] = 1'b1;
          lw_en = 1'b1;
          lw_d = sq_root[31] ? 32'h7FFF_FFFF : sq_root;
          i_nxt = k_r + 1'b1;
          j_nxt = '0;
          st_nxt = (k_r == n1_r) ? ST_DIV_WR : ST_OFF_ACC;
        end
      end
      ST_OFF_ACC: begin
        la_a = addr(i_r, j_r);
        la_b = addr(k_r, j_r);
        aa = addr(i_r, k_r);
        st_nxt = (j_r == k_r) ? ST_DIV : ST_OFF_MUL;
      end
      ST_OFF_MUL: begin
        la_a = addr(i_r, j_r);
        la_b = addr(k_r, j_r);
        aa = addr(i_r, k_r);
        if (pipe_r == 2'd1) begin
          j_nxt = j_r + 1'b1;
          st_nxt = ST_OFF_ACC;
        end
      end
      ST_DIV: begin
        aa = addr(i_r, k_r);
        lw_a = addr(i_r, k_r);
        if (pivot_r == '0) begin
          lw_en = 1'b1;
          lw_d = '0;
          st_nxt = ST_DIV_WR;
        end else if (pipe_r == 2'd0) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          lw_en = 1'b1;
          lw_d = dv_q;
          st_nxt = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        // next row, else at the last column go to emit (zeros are shown
        // for j>i), else next column
        j_nxt = '0;
        if (i_r < n1_r && k_r != n1_r) begin
          i_nxt = i_r + 1'b1;
          st_nxt = ST_OFF_ACC;
        end else if (k_r == n1_r) begin
          i_nxt = '0;
          j_nxt = '0;
          st_nxt = ST_EMIT_RD;
        end else begin
          k_nxt = k_r + 1'b1;
          st_nxt = ST_DIAG_ACC;
        end
      end
      ST_EMIT_RD: begin
        la_a = addr(i_r, j_r);
        if (!out_valid_r || out_ch.ready) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        la_a = addr(i_r, j_r);
        out_valid_nxt = 1'b1;
        out_nxt.row = IDX_W'(i_r);
        out_nxt.col = IDX_W'(j_r);
        out_nxt.value = (j_r > i_r) ? '0 : rd_r;
        out_nxt.clamped = flag_r[j_r];
        out_nxt.last = (i_r == n1_r) && (j_r == n1_r);
        if (j_r == n1_r) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
          st_nxt = (i_r == n1_r) ? ST_IDLE : ST_EMIT_RD;
          if (i_r == n1_r) begin
            i_nxt = '0;
            k_nxt = '0;
          end
        end else begin
          j_nxt = j_r + 1'b1;
          st_nxt = ST_EMIT_RD;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

### src/clf_checker.sv
`include "cholesky_lower_factor_macros.svh"
module clf_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [1:0] out_row,
  input logic [1:0] out_col,
  input logic cfg_ready
);
  `CLF_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CLF_ASSERT_IMP(a_cfg, clk, rst_n, 1'b1, cfg_ready)
  `CLF_ASSERT_IMP(a_last, clk, rst_n, out_valid && out_last, out_row == out_col)
endmodule

bind cholesky_lower_factor clf_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last), .out_row(out_ch.data.row),
  .out_col(out_ch.data.col), .cfg_ready(cfg_ch.ready)
);
